// File: sv/rcx_pkg.sv
package rcx_pkg;

    // default configuration
    localparam int CHANNEL_BITS_DEF      = 16;
    localparam int LINEAR_FRAC_BITS_DEF  = 24;
    localparam int GAMMA_TABLE_DEPTH_DEF = 256;

    // color lanes and matrix
    localparam int LANES  = 3;
    localparam int COEF_W = 20;

    typedef logic [COEF_W-1:0] coef_t;

    // linear RGB to XYZ, units of 1e-6, rows X, Y, Z and columns R, G, B
    localparam coef_t MATRIX [LANES][LANES] = '{
        '{20'd664511, 20'd154324, 20'd162028},
        '{20'd283881, 20'd668433, 20'd47685},
        '{20'd88,     20'd72310,  20'd986039}
    };

    // quotient stage
    localparam int CHROMA_W  = 16;
    localparam int QUO_BITS  = 18;
    localparam int DIV_MAX_W = 47;
    localparam logic [CHROMA_W-1:0] CHROMA_CLAMP = 16'd65279;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // restoring divide, only used to build constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] pow5_q30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // knot k of the 2.4-power curve, in lfb fraction bits
    function automatic logic [63:0] gamma_knot(input int k, input int depth, input int lfb);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] v;
        num = 64'(k) * 64'd1000 + 64'd55 * 64'(depth);
        den = 64'd1055 * 64'(depth);
        u   = udiv64((num << 30) + (den >> 1), den);
        s   = (u * u + (Q30_ONE >> 1)) >> 30;
        lo  = '0;
        hi  = Q30_ONE + 64'd1;
        for (int it = 0; it < 40; it++)
        begin
            if (hi - lo > 64'd1)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (pow5_q30(mid) <= s)
                    lo = mid;
                else
                    hi = mid;
            end
        end
        v = (s * lo + (Q30_ONE >> 1)) >> 30;
        if (lfb < 30)
            v = (v + (64'd1 << (29 - lfb))) >> (30 - lfb);
        else if (lfb > 30)
            v = v << (lfb - 30);
        return v;
    endfunction

endpackage

// File: sv/rcx_linearize.sv
module rcx_linearize #(
    parameter int CHANNEL_BITS      = rcx_pkg::CHANNEL_BITS_DEF,
    parameter int LINEAR_FRAC_BITS  = rcx_pkg::LINEAR_FRAC_BITS_DEF,
    parameter int GAMMA_TABLE_DEPTH = rcx_pkg::GAMMA_TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CHANNEL_BITS-1:0]     chan [rcx_pkg::LANES],
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [LINEAR_FRAC_BITS:0]   lin [rcx_pkg::LANES]
);
    import rcx_pkg::*;

    localparam int N      = CHANNEL_BITS;
    localparam int LW     = LINEAR_FRAC_BITS + 1;
    localparam int IDX_W  = $clog2(GAMMA_TABLE_DEPTH + 1);
    localparam int STAGES = 4;

    localparam logic [63:0] CMAX   = (64'd1 << N) - 64'd1;
    localparam logic [63:0] HALF   = CMAX / 64'd2;
    localparam logic [63:0] THRESH = (64'd4045 * CMAX) / 64'd100000;

    // linear segment: c * LA / LDEN rounded, split as c*QA + (c*RA + LB) / LDEN
    localparam logic [63:0] LDEN = CMAX * 64'd1292;
    localparam logic [63:0] LA   = 64'd100 << LINEAR_FRAC_BITS;
    localparam logic [63:0] QA   = LA / LDEN;
    localparam logic [63:0] RA   = LA % LDEN;
    localparam logic [63:0] LB   = LDEN / 64'd2;
    localparam logic [63:0] YMAX = THRESH * RA + LB;
    localparam int YW     = $clog2(YMAX + 64'd1);
    localparam int TS     = $clog2(LDEN + 64'd1) - 1;
    localparam int YH_W   = YW - TS + 1;
    localparam int US     = YH_W;
    localparam logic [63:0] RECIP = (64'd1 << (TS + US)) / LDEN;
    localparam int M_W    = $clog2(RECIP + 64'd1);
    localparam int QE_W   = $clog2(YMAX / LDEN + 64'd4);
    localparam int LDEN_W = $clog2(LDEN + 64'd1);
    localparam int QA_W   = $clog2(QA + 64'd1) + 1;

    // fold width for division by the all-ones code
    localparam int PW   = LINEAR_FRAC_BITS + N + 1;
    localparam int FOLD = (PW + N - 2) / (N - 1) + 1;

    // gamma table knots
    logic [LW-1:0] knot [GAMMA_TABLE_DEPTH+1];

    for (genvar k = 0; k <= GAMMA_TABLE_DEPTH; k++)
    begin : g_knot
        localparam logic [LW-1:0] KNOT =
            LW'(gamma_knot(k, GAMMA_TABLE_DEPTH, LINEAR_FRAC_BITS));
        assign knot[k] = KNOT;
    end

    // floor(val / CMAX) by folding the high digits back in
    function automatic logic [PW-1:0] fold_quo(input logic [PW-1:0] val);
        logic [PW-1:0] quo;
        logic [PW-1:0] rem;
        logic [PW-1:0] hi;
        quo = '0;
        rem = val;
        for (int s = 0; s < FOLD; s++)
        begin
            hi  = rem >> N;
            quo = quo + hi;
            rem = (rem & PW'(CMAX)) + hi;
        end
        for (int s = 0; s < 2; s++)
        begin
            if (rem >= PW'(CMAX))
            begin
                quo = quo + PW'(1);
                rem = rem - PW'(CMAX);
            end
        end
        return quo;
    endfunction

    logic [STAGES-1:0] ce;
    logic [STAGES-1:0] v_reg;

    always_comb
    begin
        ce[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            ce[k] = !v_reg[k] || ce[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ce[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
                if (ce[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign in_ready  = ce[0];
    assign out_valid = v_reg[STAGES-1];

    // stage a: table index and fraction, linear segment numerator
    logic [N-1:0]     a_c_reg    [LANES];
    logic             a_gam_reg  [LANES];
    logic [IDX_W-1:0] a_idx_reg  [LANES];
    logic [N-1:0]     a_frac_reg [LANES];
    logic [YW-1:0]    a_y_reg    [LANES];
    logic             a_gam_next  [LANES];
    logic [IDX_W-1:0] a_idx_next  [LANES];
    logic [N-1:0]     a_frac_next [LANES];
    logic [YW-1:0]    a_y_next    [LANES];

    always_comb
    begin
        logic [PW-1:0] p;
        logic [PW-1:0] iq;
        for (int j = 0; j < LANES; j++)
        begin
            p              = PW'(chan[j]) * PW'(GAMMA_TABLE_DEPTH);
            iq             = fold_quo(p);
            a_idx_next[j]  = IDX_W'(iq);
            a_frac_next[j] = N'(p - (iq << N) + iq);
            a_gam_next[j]  = 64'(chan[j]) > THRESH;
            a_y_next[j]    = YW'(64'(chan[j]) * RA + LB);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            a_c_reg    <= chan;
            a_gam_reg  <= a_gam_next;
            a_idx_reg  <= a_idx_next;
            a_frac_reg <= a_frac_next;
            a_y_reg    <= a_y_next;
        end
    end

    // stage b: knot lookup, reciprocal estimate
    logic [N-1:0]    b_c_reg    [LANES];
    logic            b_gam_reg  [LANES];
    logic [LW-1:0]   b_a_reg    [LANES];
    logic [LW-1:0]   b_d_reg    [LANES];
    logic [N-1:0]    b_frac_reg [LANES];
    logic [YW-1:0]   b_y_reg    [LANES];
    logic [QE_W-1:0] b_qe_reg   [LANES];
    logic [LW-1:0]   b_a_next   [LANES];
    logic [LW-1:0]   b_d_next   [LANES];
    logic [QE_W-1:0] b_qe_next  [LANES];

    always_comb
    begin
        logic [IDX_W-1:0]      nidx;
        logic [LW-1:0]         nxt;
        logic [YH_W-1:0]       yh;
        logic [YH_W+M_W-1:0]   lp;
        for (int j = 0; j < LANES; j++)
        begin
            nidx = (a_idx_reg[j] == IDX_W'(GAMMA_TABLE_DEPTH)) ?
                   a_idx_reg[j] : a_idx_reg[j] + IDX_W'(1);
            b_a_next[j] = knot[a_idx_reg[j]];
            nxt         = knot[nidx];
            b_d_next[j] = (nxt >= b_a_next[j]) ? nxt - b_a_next[j] : '0;
            yh           = YH_W'(a_y_reg[j] >> TS);
            lp           = (YH_W+M_W)'(yh) * (YH_W+M_W)'(RECIP);
            b_qe_next[j] = QE_W'(lp >> US);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            b_c_reg    <= a_c_reg;
            b_gam_reg  <= a_gam_reg;
            b_a_reg    <= b_a_next;
            b_d_reg    <= b_d_next;
            b_frac_reg <= a_frac_reg;
            b_y_reg    <= a_y_reg;
            b_qe_reg   <= b_qe_next;
        end
    end

    // stage c: interpolation product, linear segment result
    logic          c_gam_reg  [LANES];
    logic [LW-1:0] c_a_reg    [LANES];
    logic [PW-1:0] c_prod_reg [LANES];
    logic [LW-1:0] c_seg_reg  [LANES];
    logic [PW-1:0] c_prod_next [LANES];
    logic [LW-1:0] c_seg_next  [LANES];

    always_comb
    begin
        logic [YW-1:0]   rr;
        logic [QE_W-1:0] q;
        for (int j = 0; j < LANES; j++)
        begin
            c_prod_next[j] = PW'(b_d_reg[j]) * PW'(b_frac_reg[j]) + PW'(HALF);
            rr = b_y_reg[j]
               - YW'((QE_W+LDEN_W)'(b_qe_reg[j]) * (QE_W+LDEN_W)'(LDEN));
            q  = b_qe_reg[j]
               + QE_W'(64'(rr) >= LDEN)
               + QE_W'(64'(rr) >= LDEN * 64'd2)
               + QE_W'(64'(rr) >= LDEN * 64'd3);
            c_seg_next[j] = LW'((N+QA_W)'(b_c_reg[j]) * (N+QA_W)'(QA)) + LW'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[2])
        begin
            c_gam_reg  <= b_gam_reg;
            c_a_reg    <= b_a_reg;
            c_prod_reg <= c_prod_next;
            c_seg_reg  <= c_seg_next;
        end
    end

    // stage d: interpolation divide and segment select
    logic [LW-1:0] d_lin_reg  [LANES];
    logic [LW-1:0] d_lin_next [LANES];

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
            d_lin_next[j] = c_gam_reg[j] ? c_a_reg[j] + LW'(fold_quo(c_prod_reg[j]))
                                         : c_seg_reg[j];
    end

    always_ff @(posedge clk)
    begin
        if (ce[3])
            d_lin_reg <= d_lin_next;
    end

    assign lin = d_lin_reg;

endmodule

// File: sv/rcx_matrix.sv
module rcx_matrix #(
    parameter int LINEAR_FRAC_BITS = rcx_pkg::LINEAR_FRAC_BITS_DEF,
    parameter int DIV_W            = rcx_pkg::DIV_MAX_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [LINEAR_FRAC_BITS:0]  lin [rcx_pkg::LANES],
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [DIV_W-1:0]           part [2],
    output logic [DIV_W-1:0]           den,
    output logic                       zero
);
    import rcx_pkg::*;

    localparam int LW     = LINEAR_FRAC_BITS + 1;
    localparam int PRW    = LW + COEF_W;
    localparam int SW     = LINEAR_FRAC_BITS + 22;
    localparam int STAGES = 4;

    logic [STAGES-1:0] ce;
    logic [STAGES-1:0] v_reg;

    always_comb
    begin
        ce[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            ce[k] = !v_reg[k] || ce[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ce[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
                if (ce[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign in_ready  = ce[0];
    assign out_valid = v_reg[STAGES-1];

    // products
    logic [PRW-1:0] prod_reg  [LANES][LANES];
    logic [PRW-1:0] prod_next [LANES][LANES];

    always_comb
    begin
        for (int r = 0; r < LANES; r++)
            for (int c = 0; c < LANES; c++)
                prod_next[r][c] = PRW'(lin[c]) * PRW'(MATRIX[r][c]);
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
            prod_reg <= prod_next;
    end

    // row sums X, Y, Z
    logic [SW-1:0] row_reg  [LANES];
    logic [SW-1:0] row_next [LANES];

    always_comb
    begin
        for (int r = 0; r < LANES; r++)
            row_next[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2]);
    end

    always_ff @(posedge clk)
    begin
        if (ce[1])
            row_reg <= row_next;
    end

    // X, Y and the total
    logic [SW-1:0] x_reg;
    logic [SW-1:0] y_reg;
    logic [SW-1:0] s_reg;

    always_ff @(posedge clk)
    begin
        if (ce[2])
        begin
            x_reg <= row_reg[0];
            y_reg <= row_reg[1];
            s_reg <= row_reg[0] + row_reg[1] + row_reg[2];
        end
    end

    // scale down so the total fits the divider
    logic [DIV_W-1:0] px_next;
    logic [DIV_W-1:0] py_next;
    logic [DIV_W-1:0] pd_next;

    if (SW > DIV_MAX_W)
    begin : g_norm
        localparam int SH_W = $clog2(SW - DIV_MAX_W + 1);
        logic [SH_W-1:0] sh;

        always_comb
        begin
            sh = '0;
            for (int b = DIV_MAX_W; b < SW; b++)
                if (s_reg[b])
                    sh = SH_W'(b - DIV_MAX_W + 1);
            px_next = DIV_W'(x_reg >> sh);
            py_next = DIV_W'(y_reg >> sh);
            pd_next = DIV_W'(s_reg >> sh);
        end
    end
    else
    begin : g_pass
        assign px_next = DIV_W'(x_reg);
        assign py_next = DIV_W'(y_reg);
        assign pd_next = DIV_W'(s_reg);
    end

    logic [DIV_W-1:0] px_reg;
    logic [DIV_W-1:0] py_reg;
    logic [DIV_W-1:0] pd_reg;
    logic             zero_reg;

    always_ff @(posedge clk)
    begin
        if (ce[3])
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pd_reg   <= pd_next;
            zero_reg <= (s_reg == '0);
        end
    end

    assign part[0] = px_reg;
    assign part[1] = py_reg;
    assign den     = pd_reg;
    assign zero    = zero_reg;

endmodule

// File: sv/rcx_divide.sv
module rcx_divide #(
    parameter int DIV_W = rcx_pkg::DIV_MAX_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [DIV_W-1:0]               part [2],
    input  logic [DIV_W-1:0]               den,
    input  logic                           zero,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rcx_pkg::CHROMA_W-1:0]   chroma [2]
);
    import rcx_pkg::*;

    localparam int DIV_STEP = 2;
    localparam int NST      = QUO_BITS / DIV_STEP;
    localparam int STAGES   = NST + 1;
    localparam int RW       = DIV_W + 1;

    logic [STAGES-1:0] ce;
    logic [STAGES-1:0] v_reg;

    always_comb
    begin
        ce[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            ce[k] = !v_reg[k] || ce[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ce[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
                if (ce[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign in_ready  = ce[0];
    assign out_valid = v_reg[STAGES-1];

    logic [RW-1:0]       rem_reg  [NST][2];
    logic [QUO_BITS-1:0] quo_reg  [NST][2];
    logic [DIV_W-1:0]    den_reg  [NST];
    logic                zero_reg [NST];

    // restoring divide, two quotient bits per stage
    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        logic [RW-1:0]       rem_src  [2];
        logic [QUO_BITS-1:0] quo_src  [2];
        logic [DIV_W-1:0]    den_src;
        logic                zero_src;
        logic [RW-1:0]       rem_next [2];
        logic [QUO_BITS-1:0] quo_next [2];

        if (k == 0)
        begin : g_first
            assign rem_src[0] = RW'(part[0]);
            assign rem_src[1] = RW'(part[1]);
            assign quo_src[0] = '0;
            assign quo_src[1] = '0;
            assign den_src    = den;
            assign zero_src   = zero;
        end
        else
        begin : g_rest
            assign rem_src  = rem_reg[k-1];
            assign quo_src  = quo_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign zero_src = zero_reg[k-1];
        end

        always_comb
        begin
            logic [RW-1:0]       r;
            logic [QUO_BITS-1:0] q;
            for (int l = 0; l < 2; l++)
            begin
                r = rem_src[l];
                q = quo_src[l];
                for (int t = 0; t < DIV_STEP; t++)
                begin
                    if (k * DIV_STEP + t > 0)
                        r = r << 1;
                    if (r >= RW'(den_src))
                    begin
                        r = r - RW'(den_src);
                        q[QUO_BITS-1-(k*DIV_STEP+t)] = 1'b1;
                    end
                end
                rem_next[l] = r;
                quo_next[l] = q;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce[k])
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= den_src;
                zero_reg[k] <= zero_src;
            end
        end
    end

    // round half up, clamp, black gives zero
    logic [CHROMA_W-1:0] chroma_reg  [2];
    logic [CHROMA_W-1:0] chroma_next [2];

    always_comb
    begin
        logic [QUO_BITS-1:0] qr;
        for (int l = 0; l < 2; l++)
        begin
            qr = (quo_reg[NST-1][l] + QUO_BITS'(1)) >> 1;
            if (zero_reg[NST-1])
                chroma_next[l] = '0;
            else if (qr > QUO_BITS'(CHROMA_CLAMP))
                chroma_next[l] = CHROMA_CLAMP;
            else
                chroma_next[l] = CHROMA_W'(qr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[NST])
            chroma_reg <= chroma_next;
    end

    assign chroma = chroma_reg;

endmodule

// File: sv/rgb_to_cie_xy_chromaticity.sv
// sRGB pixel to CIE 1931 xy chromaticity. Each request carries one pixel as three
// unsigned fractions (all ones means 1.0, only the low CHANNEL_BITS bits count);
// the result is x = X/(X+Y+Z) and y = Y/(X+Y+Z) times 65536, rounded half up and
// clamped to 65279, with 0,0 for black and for pixels so dark that every linear
// value rounds to zero. The gamma curve is a constant table of GAMMA_TABLE_DEPTH+1
// knots with linear interpolation below which a straight segment takes over.
// The pipeline takes one pixel per clock while the output is not held off and holds
// up to 18 in flight: 4 stages of gamma removal, 4 of matrix and scaling, 9 of
// restoring division at two quotient bits each and one of rounding. A stalled
// output stops only the stages that are full; empty stages keep taking requests.
module rgb_to_cie_xy_chromaticity #(
    parameter int CHANNEL_BITS      = rcx_pkg::CHANNEL_BITS_DEF,
    parameter int LINEAR_FRAC_BITS  = rcx_pkg::LINEAR_FRAC_BITS_DEF,
    parameter int GAMMA_TABLE_DEPTH = rcx_pkg::GAMMA_TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    output logic        chroma_valid,
    input  logic        chroma_ready,
    output logic [15:0] chroma_x,
    output logic [15:0] chroma_y
);
    import rcx_pkg::*;

    // width of X+Y+Z and of the divider after scaling
    localparam int SUM_W = LINEAR_FRAC_BITS + 22;
    localparam int DIV_W = (SUM_W > DIV_MAX_W) ? DIV_MAX_W : SUM_W;

    // input channels, upper bits dropped
    logic [CHANNEL_BITS-1:0]   chan [LANES];

    assign chan[0] = red[CHANNEL_BITS-1:0];
    assign chan[1] = green[CHANNEL_BITS-1:0];
    assign chan[2] = blue[CHANNEL_BITS-1:0];

    // gamma removal to linear light
    logic                      lin_valid;
    logic                      lin_ready;
    logic [LINEAR_FRAC_BITS:0] lin [LANES];

    rcx_linearize #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .LINEAR_FRAC_BITS  (LINEAR_FRAC_BITS),
        .GAMMA_TABLE_DEPTH (GAMMA_TABLE_DEPTH)
    ) u_linearize (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (pixel_ready),
        .chan      (chan),
        .out_valid (lin_valid),
        .out_ready (lin_ready),
        .lin       (lin)
    );

    // XYZ matrix, sum and scaling for the divider
    logic             mat_valid;
    logic             mat_ready;
    logic [DIV_W-1:0] part [2];
    logic [DIV_W-1:0] den;
    logic             zero;

    rcx_matrix #(
        .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
        .DIV_W            (DIV_W)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_valid),
        .in_ready  (lin_ready),
        .lin       (lin),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .part      (part),
        .den       (den),
        .zero      (zero)
    );

    // x and y quotients side by side
    logic [CHROMA_W-1:0] chroma [2];

    rcx_divide #(
        .DIV_W (DIV_W)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .part      (part),
        .den       (den),
        .zero      (zero),
        .out_valid (chroma_valid),
        .out_ready (chroma_ready),
        .chroma    (chroma)
    );

    assign chroma_x = chroma[0];
    assign chroma_y = chroma[1];

endmodule
